// ----- src/zsce_pkg.sv -----
// ----------------------------------------------------------------------------
// zsce_pkg
// Types, constants and codes shared by the zoomed sprite chunk expander.
// ----------------------------------------------------------------------------
package zsce_pkg;

  localparam int MAP_DEPTH_DEF = 524288;
  localparam int MAP_ADDR_IN_W = 19;
  localparam int MAP_WORD_W    = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VARIANT       = 3'd0,
    CFG_X_OFFSET      = 3'd1,
    CFG_Y_OFFSET      = 3'd2,
    CFG_PRIMASK_ZERO  = 3'd3,
    CFG_PRIMASK_ONE   = 3'd4,
    CFG_PRIMASK_TWO   = 3'd5,
    CFG_PRIMASK_THREE = 3'd6
  } cfg_index_t;

  localparam logic [9:0]  X_OFFSET_RST    = 10'sd44;
  localparam logic [10:0] Y_OFFSET_RST    = 11'h5c2;  // -574
  localparam logic [15:0] PRIMASK_ZERO_RST  = 16'hfffc;
  localparam logic [15:0] PRIMASK_ONE_RST   = 16'hfff0;
  localparam logic [15:0] PRIMASK_TWO_RST   = 16'hff00;
  localparam logic [15:0] PRIMASK_THREE_RST = 16'h0000;

  localparam logic signed [12:0] COORD_FOLD = 13'sh340;
  localparam logic signed [12:0] COORD_WRAP = 13'sh400;
  localparam logic [15:0]        INVALID_CODE = 16'hffff;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_EXPAND = 1'b1;

  typedef struct packed {
    logic        action;
    logic [18:0] map_address;
    logic [23:0] map_word;
    logic [31:0] attr_word_a;
    logic [31:0] attr_word_b;
    logic [31:0] attr_word_c;
  } in_item_t;

  typedef struct packed {
    logic               chunk_valid;
    logic [23:0]        chunk_code;
    logic [7:0]         palette;
    logic               flip_horizontal;
    logic               flip_vertical;
    logic signed [11:0] screen_x;
    logic signed [11:0] screen_y;
    logic [6:0]         chunk_width;
    logic [6:0]         chunk_height;
    logic [1:0]         priority_res;
    logic [15:0]        priority_mask;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic mod_start;
    logic mem_write;
    logic mem_read;
    logic out_load;
    logic chunk_next;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_store;
    logic tile_zero;
    logic mod_done;
    logic out_free;
    logic last_chunk;
  } ctrl_status_t;

endpackage

// ----- src/zsce_addr_mod.sv -----
// ----------------------------------------------------------------------------
// zsce_addr_mod
// Reduction of a map address modulo the map store depth by reciprocal
// multiplication: quotient estimate, remainder, one correction subtract.
// ----------------------------------------------------------------------------
module zsce_addr_mod
  import zsce_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [MAP_ADDR_IN_W-1:0]     value,
  output logic [$clog2(MAP_DEPTH)-1:0] result,
  output logic                         done
);

  localparam int AW    = $clog2(MAP_DEPTH);
  localparam int VW    = MAP_ADDR_IN_W + 1;
  // floor(2^19 / depth): the estimate is the true quotient or one below it
  localparam int RECIP = (1 << MAP_ADDR_IN_W) / MAP_DEPTH;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = MAP_ADDR_IN_W + RW;
  localparam logic [VW-1:0] DEPTH_W = VW'(MAP_DEPTH);

  logic [MAP_ADDR_IN_W-1:0] val;
  logic [PW-1:0]            prod;
  logic [RW-1:0]            quot;
  logic [VW-1:0]            qd;
  logic [VW-1:0]            rem;
  logic [2:0]               phase;

  assign prod = PW'(val) * PW'(RECIP);
  assign qd   = VW'(quot) * DEPTH_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (start) begin
      phase <= 3'b001;
    end else begin
      phase <= {phase[1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) val <= value;
    if (phase[0]) quot <= prod[PW-1 -: RW];
    if (phase[1]) begin
      rem <= {1'b0, val} - qd;
    end else if (phase[2] && rem >= DEPTH_W) begin
      rem <= rem - DEPTH_W;
    end
  end

  assign result = rem[AW-1:0];
  assign done   = (phase == 3'b000);

endmodule

// ----- src/zsce_datapath.sv -----
// ----------------------------------------------------------------------------
// zsce_datapath
// Configuration registers, item capture, map store, chunk address and
// result formatting with the output register.
// ----------------------------------------------------------------------------
module zsce_datapath
  import zsce_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int AW = $clog2(MAP_DEPTH);

  // configuration
  logic               variant;
  logic signed [9:0]  x_offset;
  logic signed [10:0] y_offset;
  logic [15:0]        primask [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      variant    <= 1'b0;
      x_offset   <= X_OFFSET_RST;
      y_offset   <= Y_OFFSET_RST;
      primask[0] <= PRIMASK_ZERO_RST;
      primask[1] <= PRIMASK_ONE_RST;
      primask[2] <= PRIMASK_TWO_RST;
      primask[3] <= PRIMASK_THREE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VARIANT:       variant    <= cfg_data[0];
        CFG_X_OFFSET:      x_offset   <= signed'(cfg_data[9:0]);
        CFG_Y_OFFSET:      y_offset   <= signed'(cfg_data[10:0]);
        CFG_PRIMASK_ZERO:  primask[0] <= cfg_data;
        CFG_PRIMASK_ONE:   primask[1] <= cfg_data;
        CFG_PRIMASK_TWO:   primask[2] <= cfg_data;
        CFG_PRIMASK_THREE: primask[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // item decode at capture
  logic signed [12:0] x_raw, x_fold, x_pos;
  logic [9:0]         y_base;
  logic signed [12:0] y_sum, y_pos;
  logic [7:0]         pal_in;

  always_comb begin
    x_raw  = signed'({3'b000, in_data.attr_word_b[9:0]});
    x_fold = (x_raw > COORD_FOLD) ? x_raw - COORD_WRAP : x_raw;
    x_pos  = x_fold - signed'({{3{x_offset[9]}}, x_offset});
    y_base = variant ? in_data.attr_word_c[9:0] : 10'(10'd0 - in_data.attr_word_c[9:0]);
    y_sum  = signed'({3'b000, y_base}) + signed'({{2{y_offset[10]}}, y_offset});
    y_pos  = (y_sum > COORD_FOLD) ? y_sum - COORD_WRAP : y_sum;
    // bank bit, priority merged into the top palette bits, then halved
    pal_in = {~variant,
              in_data.attr_word_b[17] | in_data.attr_word_b[19],
              in_data.attr_word_b[16] | in_data.attr_word_b[18],
              in_data.attr_word_b[15:11]};
  end

  logic                     is_store;
  logic [MAP_ADDR_IN_W-1:0] load_addr;
  logic [MAP_WORD_W-1:0]    map_word;
  logic [15:0]              tile;
  logic                     fx, fy, big;
  logic [7:0]               zx, zy;
  logic [1:0]               pri;
  logic [7:0]               pal;
  logic signed [12:0]       x0, y0;
  logic                     var_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_store  <= (in_data.action == ACTION_LOAD);
      load_addr <= in_data.map_address;
      map_word  <= in_data.map_word;
      tile      <= {in_data.attr_word_a[15] & variant, in_data.attr_word_a[14:0]};
      fx        <= in_data.attr_word_a[23];
      zx        <= {1'b0, in_data.attr_word_a[22:16]} + 8'd1;
      pri       <= in_data.attr_word_b[19:18];
      pal       <= pal_in;
      big       <= in_data.attr_word_c[18];
      fy        <= in_data.attr_word_c[17] ^ variant;
      zy        <= {1'b0, in_data.attr_word_c[16:10]} + 8'd1;
      x0        <= x_pos;
      y0        <= y_pos;
      var_r     <= variant;
    end
  end

  // chunk counter
  logic [3:0] n;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n <= '0;
    end else if (cmd.chunk_next) begin
      n <= n + 4'd1;
    end
  end

  logic [1:0] col, row, px, py, flip_mask;
  logic [4:0] py_off;
  logic [MAP_ADDR_IN_W-1:0] chunk_addr;

  always_comb begin
    col       = big ? n[1:0] : {1'b0, n[0]};
    row       = big ? n[3:2] : {1'b0, n[1]};
    flip_mask = big ? 2'b11 : 2'b01;
    px        = fx ? col ^ flip_mask : col;
    py        = fy ? row ^ flip_mask : row;
    py_off    = big ? {1'b0, py, 2'b00} : {2'b00, py, 1'b0};
    chunk_addr = {1'b0, tile, 2'b00} + MAP_ADDR_IN_W'(px) + MAP_ADDR_IN_W'(py_off);
  end

  // address reduction
  logic [AW-1:0] mod_addr;
  logic          mod_done;

  zsce_addr_mod #(
    .MAP_DEPTH(MAP_DEPTH)
  ) u_addr_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mod_start),
    .value  (is_store ? load_addr : chunk_addr),
    .result (mod_addr),
    .done   (mod_done)
  );

  // map store
  logic [MAP_WORD_W-1:0] mem [MAP_DEPTH];
  logic [MAP_WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.mem_write) mem[mod_addr] <= map_word;
    if (cmd.mem_read)  rd_data <= mem[mod_addr];
  end

  // result formatting
  logic [9:0]         lo_prod;
  logic [10:0]        hi_prod;
  logic [9:0]         lo_col, hi_col, lo_row, hi_row;
  logic [9:0]         lo_rprod;
  logic [10:0]        hi_rprod;
  logic signed [12:0] cx, cy;
  logic               invalid;
  out_item_t          res;

  always_comb begin
    lo_prod  = 10'(col) * 10'(zx);
    hi_prod  = 11'({1'b0, col} + 3'd1) * 11'(zx);
    lo_rprod = 10'(row) * 10'(zy);
    hi_rprod = 11'({1'b0, row} + 3'd1) * 11'(zy);
    lo_col   = big ? 10'(lo_prod >> 2)  : 10'(lo_prod >> 1);
    hi_col   = big ? 10'(hi_prod >> 2)  : 10'(hi_prod >> 1);
    lo_row   = big ? 10'(lo_rprod >> 2) : 10'(lo_rprod >> 1);
    hi_row   = big ? 10'(hi_rprod >> 2) : 10'(hi_rprod >> 1);
    cx       = x0 + signed'({3'b000, lo_col});
    cy       = y0 + signed'({3'b000, lo_row});
    invalid  = !var_r && (rd_data[15:0] == INVALID_CODE);

    res = '0;
    if (!invalid) begin
      res.chunk_valid     = 1'b1;
      res.chunk_code      = var_r ? rd_data : {8'h00, rd_data[15:0]};
      res.palette         = pal;
      res.flip_horizontal = ~fx;
      res.flip_vertical   = fy;
      res.screen_x        = cx[11:0];
      res.screen_y        = cy[11:0];
      res.chunk_width     = 7'(hi_col - lo_col);
      res.chunk_height    = 7'(hi_row - lo_row);
      res.priority_res    = pri;
      res.priority_mask   = primask[pri];
    end
    res.last = status.last_chunk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= res;
  end

  assign status.is_store   = is_store;
  assign status.tile_zero  = (tile == 16'd0);
  assign status.mod_done   = mod_done;
  assign status.out_free   = !out_valid || out_ready;
  assign status.last_chunk = big ? (n == 4'd15) : (n == 4'd3);

endmodule

// ----- src/zsce_ctrl.sv -----
// ----------------------------------------------------------------------------
// zsce_ctrl
// Sequencer: capture, address reduction, map store access and one
// result per chunk.
// ----------------------------------------------------------------------------
module zsce_ctrl
  import zsce_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_ADDR   = 5'b00100,
    S_WAIT   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.is_store && status.tile_zero) state_next = S_IDLE;
        else                                      state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.mod_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.mod_done) begin
          if (status.is_store) begin
            cmd.mem_write = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.mem_read = 1'b1;
            state_next   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.last_chunk) begin
            state_next = S_IDLE;
          end else begin
            cmd.chunk_next = 1'b1;
            state_next     = S_ADDR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/zoomed_sprite_chunk_expander_core.sv -----
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_core
// Expands sprite entries into zoomed 16x16 chunks read from a map store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries either a map store
//   load (action 0) or a sprite entry to expand (action 1). One item is
//   taken at a time; in_ready is high while the sequencer is idle.
//   Output channel (out_valid/out_ready/out_data) gives 4 or 16 chunks per
//   sprite in row order, last set on the final one. A sprite with tile zero
//   gives nothing; a load gives nothing.
//   Timing: with the receiver keeping up, a chunk goes through address
//   setup, address reduction, the map store read and the output register
//   load. An entry first goes through a decode step, where a tile-zero
//   entry ends; a load goes through decode, address setup, address
//   reduction and the map store write. The sequencer accepts the next item
//   while the last result waits in the output register.
//   If the receiver stalls, the sequencer holds in its emit step until the
//   output register frees up; nothing is dropped.
//   Reset (rst, synchronous) returns configuration registers to defaults,
//   empties the output register and idles the sequencer. The map store is
//   not cleared. Config writes go through cfg_write/cfg_index/cfg_data;
//   the user must make them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander_core
  import zsce_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  zsce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  zsce_datapath #(
    .MAP_DEPTH(MAP_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/zsce_checker.sv -----
// ----------------------------------------------------------------------------
// zsce_checker
// Port-level checks for the chunk expander, bound to the top level.
// ----------------------------------------------------------------------------
module zsce_checker
  import zsce_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output payload changed while stalled");

  // output register is empty right after reset
  a_out_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // one item at a time: busy after a transfer in
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // an invalid chunk carries only the last flag
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.chunk_valid |->
      out_data.chunk_code == 24'd0 && out_data.priority_mask == 16'd0 &&
      out_data.screen_x == 12'sd0 && out_data.chunk_width == 7'd0)
    else $error("invalid chunk with nonzero fields");

endmodule

bind zoomed_sprite_chunk_expander_core zsce_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/chunk_checker.sv -----
// ----------------------------------------------------------------------------
// chunk_checker
// Watches both channels and the register port of the sprite chunk expander,
// predicts the chunks of every accepted sprite entry and compares them in
// order with the chunks the block transfers.
// ----------------------------------------------------------------------------
module chunk_checker
  import zsce_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic        variant_q;
  logic [9:0]  x_off_q;
  logic [10:0] y_off_q;
  logic [15:0] primask_q [4];

  logic [23:0] map_shadow [int];
  out_item_t   chunks_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic expand_sprite(input in_item_t it);
    logic [15:0] tile;
    logic        fx, fy, big;
    logic [1:0]  pri;
    logic [7:0]  pal;
    logic [23:0] word;
    int          zx, zy, x, y, dim, total, row, col, px, py, cx, cy, addr;
    out_item_t   o;
    fx   = it.attr_word_a[23];
    zx   = int'(it.attr_word_a[22:16]) + 1;
    tile = variant_q ? it.attr_word_a[15:0] : {1'b0, it.attr_word_a[14:0]};
    pri  = it.attr_word_b[19:18];
    x    = int'(it.attr_word_b[9:0]);
    big  = it.attr_word_c[18];
    fy   = it.attr_word_c[17];
    zy   = int'(it.attr_word_c[16:10]) + 1;
    y    = int'(it.attr_word_c[9:0]);
    if (tile == 16'h0) return;
    // first form merges palette bank 0x100 and mirrors y; second form flips y
    if (!variant_q) begin
      pal = 8'((int'(it.attr_word_b[17:10]) | 'h100 | (int'(pri) << 6)) >> 1);
      y   = (1024 - y) & 'h3ff;
    end else begin
      pal = 8'((int'(it.attr_word_b[17:10]) | (int'(pri) << 6)) >> 1);
      fy  = !fy;
    end
    y = y + int'($signed(y_off_q));
    if (x > int'(COORD_FOLD)) x = x - int'(COORD_WRAP);
    if (y > int'(COORD_FOLD)) y = y - int'(COORD_WRAP);
    x     = x - int'($signed(x_off_q));
    dim   = big ? 4 : 2;
    total = dim * dim;
    for (int n = 0; n < total; n++) begin
      row  = n / dim;
      col  = n % dim;
      px   = fx ? dim - 1 - col : col;
      py   = fy ? dim - 1 - row : row;
      addr = (int'(tile) * 4 + px + py * dim) % MAP_DEPTH;
      word = map_shadow.exists(addr) ? map_shadow[addr] : 24'h0;
      o      = '0;
      o.last = (n == total - 1);
      if (variant_q || word[15:0] != INVALID_CODE) begin
        cx = x + (col * zx) / dim;
        cy = y + (row * zy) / dim;
        o.chunk_valid     = 1'b1;
        o.chunk_code      = variant_q ? word : {8'h0, word[15:0]};
        o.palette         = pal;
        o.flip_horizontal = !fx;
        o.flip_vertical   = fy;
        o.screen_x        = 12'(cx);
        o.screen_y        = 12'(cy);
        o.chunk_width     = 7'(((col + 1) * zx) / dim - (col * zx) / dim);
        o.chunk_height    = 7'(((row + 1) * zy) / dim - (row * zy) / dim);
        o.priority_res    = pri;
        o.priority_mask   = primask_q[pri];
      end
      chunks_due.push_back(o);
    end
  endtask

  task automatic field_diff(input string name, input logic [23:0] exp_v,
                            input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: chunk %s mismatch, expected %0h, got %0h", $time, name, exp_v,
               act_v);
      errors++;
    end
  endtask

  task automatic check_chunk(input out_item_t act);
    out_item_t exp_c;
    if (chunks_due.size() == 0) begin
      $display("%0t: unexpected chunk, expected none, got %h", $time, act);
      errors++;
      return;
    end
    exp_c = chunks_due.pop_front();
    if (exp_c !== act) begin
      field_diff("chunk_valid", 24'(exp_c.chunk_valid), 24'(act.chunk_valid));
      field_diff("chunk_code", exp_c.chunk_code, act.chunk_code);
      field_diff("palette", 24'(exp_c.palette), 24'(act.palette));
      field_diff("flip_horizontal", 24'(exp_c.flip_horizontal),
                 24'(act.flip_horizontal));
      field_diff("flip_vertical", 24'(exp_c.flip_vertical), 24'(act.flip_vertical));
      field_diff("screen_x", 24'(exp_c.screen_x), 24'(act.screen_x));
      field_diff("screen_y", 24'(exp_c.screen_y), 24'(act.screen_y));
      field_diff("chunk_width", 24'(exp_c.chunk_width), 24'(act.chunk_width));
      field_diff("chunk_height", 24'(exp_c.chunk_height), 24'(act.chunk_height));
      field_diff("priority_res", 24'(exp_c.priority_res), 24'(act.priority_res));
      field_diff("priority_mask", 24'(exp_c.priority_mask), 24'(act.priority_mask));
      field_diff("last", 24'(exp_c.last), 24'(act.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      variant_q    = 1'b0;
      x_off_q      = X_OFFSET_RST;
      y_off_q      = Y_OFFSET_RST;
      primask_q[0] = PRIMASK_ZERO_RST;
      primask_q[1] = PRIMASK_ONE_RST;
      primask_q[2] = PRIMASK_TWO_RST;
      primask_q[3] = PRIMASK_THREE_RST;
      chunks_due.delete();
    end else begin
      // output first: a chunk can never stem from an entry taken this edge
      if (out_valid && out_ready) check_chunk(out_data);
      if (in_valid && in_ready) begin
        if (in_data.action == ACTION_LOAD)
          map_shadow[int'(in_data.map_address) % MAP_DEPTH] = in_data.map_word;
        else
          expand_sprite(in_data);
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_VARIANT:       variant_q    = cfg_data[0];
          CFG_X_OFFSET:      x_off_q      = cfg_data[9:0];
          CFG_Y_OFFSET:      y_off_q      = cfg_data[10:0];
          CFG_PRIMASK_ZERO:  primask_q[0] = cfg_data;
          CFG_PRIMASK_ONE:   primask_q[1] = cfg_data;
          CFG_PRIMASK_TWO:   primask_q[2] = cfg_data;
          CFG_PRIMASK_THREE: primask_q[3] = cfg_data;
          default: ;
        endcase
      end
    end
    pending = chunks_due.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives map loads and sprite entries into the chunk expander under random
// idling on both channels, across several register settings, and reports
// the verdict of the chunk checker.
// ----------------------------------------------------------------------------
module testbench;
  import zsce_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 38;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_VARIANT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   errors;
  int   pending;
  int   cycles = 0;
  int   items_sent = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  logic variant_now = 1'b0;
  bit   loaded [int];
  int   used_tiles [$];

  zoomed_sprite_chunk_expander_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chunk_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // chunk receiver; a hold request stalls it for a long stretch
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [23:0] random_map_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return {8'($urandom), 16'hffff};
    if (pick < 30) return 24'h0;
    return 24'($urandom);
  endfunction

  task automatic load_word(input int addr, input logic [23:0] word);
    in_item_t it;
    it.action      = ACTION_LOAD;
    it.map_address = 19'(addr);
    it.map_word    = word;
    it.attr_word_a = $urandom;
    it.attr_word_b = $urandom;
    it.attr_word_c = $urandom;
    send_item(it);
    loaded[addr] = 1'b1;
  endtask

  task automatic send_sprite(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
    in_item_t it;
    it.action      = ACTION_EXPAND;
    it.map_address = 19'($urandom);
    it.map_word    = 24'($urandom);
    it.attr_word_a = a;
    it.attr_word_b = b;
    it.attr_word_c = c;
    send_item(it);
  endtask

  // every map word a sprite can touch has to be loaded before it is sent
  task automatic fill_tile(input int tile, input int words);
    for (int i = 0; i < words; i++)
      if (!loaded.exists(tile * 4 + i)) load_word(tile * 4 + i, random_map_word());
  endtask

  task automatic random_sprite();
    int          tile, words;
    logic [31:0] a, b, c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    words = c[18] ? 16 : 4;
    if (used_tiles.size() > 0 && $urandom_range(0, 99) < 80)
      tile = used_tiles[$urandom_range(0, used_tiles.size() - 1)];
    else
      tile = $urandom_range(1, 'hffff);
    if (!variant_now) tile = tile & 'h7fff;
    if ($urandom_range(0, 99) < 6) tile = 0;
    if (tile != 0) begin
      fill_tile(tile, words);
      if ($urandom_range(0, 99) < 20)
        load_word(tile * 4 + $urandom_range(0, words - 1), random_map_word());
      if (used_tiles.size() < 100) used_tiles.push_back(tile);
    end
    a[15:0] = 16'(tile);
    // the first form ignores the top tile bit
    if (!variant_now) a[15] = 1'($urandom);
    send_sprite(a, b, c);
  endtask

  task automatic random_phase(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 10)
        load_word($urandom_range(0, 'h7ffff), random_map_word());
      else
        random_sprite();
    end
    no_idle = 1'b0;
  endtask

  // wait until every chunk has been transferred and the block is idle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = 16'(value);
  endtask

  task automatic configure(input logic v, input int xo, input int yo, input int m0,
                           input int m1, input int m2, input int m3);
    write_reg(CFG_VARIANT, int'(v));
    write_reg(CFG_X_OFFSET, xo);
    write_reg(CFG_Y_OFFSET, yo);
    write_reg(CFG_PRIMASK_ZERO, m0);
    write_reg(CFG_PRIMASK_ONE, m1);
    write_reg(CFG_PRIMASK_TWO, m2);
    write_reg(CFG_PRIMASK_THREE, m3);
    @(negedge clk);
    cfg_write   = 1'b0;
    variant_now = v;
  endtask

  task automatic directed_items();
    logic [23:0] word;
    // tile 1 region with invalid, zero and extreme codes
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       word = 24'h000001;
        1:       word = 24'h12ffff;
        2:       word = 24'h000000;
        3:       word = 24'hfffffe;
        15:      word = 24'hffffff;
        default: word = 24'($urandom);
      endcase
      load_word(4 + i, word);
    end
    send_sprite({8'h00, 1'b0, 7'h00, 16'h0001}, 32'h0, 32'h0);
    send_sprite({8'hff, 1'b1, 7'h7f, 16'h0001}, {12'hfff, 2'd3, 8'hff, 10'h3ff},
                {13'h1fff, 1'b1, 1'b1, 7'h7f, 10'h3ff});
    send_sprite(32'h00ff_0000, $urandom, $urandom);
    send_sprite({8'h00, 1'b0, 7'h10, 16'h8001}, {12'h0, 2'd1, 8'h5a, 10'h341},
                {13'h0, 1'b1, 1'b0, 7'h40, 10'h340});
    send_sprite({8'h00, 1'b1, 7'h1f, 16'h0001}, {12'h0, 2'd2, 8'h81, 10'h340},
                {13'h0, 1'b0, 1'b1, 7'h0f, 10'h001});
    load_word('h7ffff, 24'hffffff);
    load_word(0, 24'h0);
    used_tiles.push_back(1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_items();
    drain();

    // receiver stalls while entries keep coming
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    configure(1'b1, -512, 1023, 'hffff, 'h0000, 'ha5a5, 'h5a5a);
    random_phase(PHASE_ITEMS);
    drain();

    configure(1'b0, 511, -1024, 'h0000, 'hffff, 'h1234, 'hfedc);
    random_phase(PHASE_ITEMS);
    drain();

    configure(1'b1, $urandom_range(0, 1023) - 512, $urandom_range(0, 2047) - 1024,
              $urandom_range(0, 'hffff), $urandom_range(0, 'hffff),
              $urandom_range(0, 'hffff), $urandom_range(0, 'hffff));
    random_phase(PHASE_ITEMS);
    drain();

    configure(1'b0, $urandom_range(0, 1023) - 512, $urandom_range(0, 2047) - 1024,
              $urandom_range(0, 'hffff), $urandom_range(0, 'hffff),
              $urandom_range(0, 'hffff), $urandom_range(0, 'hffff));
    random_phase(PHASE_ITEMS);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
